// ===== rtl/ppp_pkg.sv =====
package ppp_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF   = 16;

  // matrix entries and pitch are fixed Q16.16
  localparam int unsigned COEF_W     = 32;
  localparam int unsigned PITCH_W    = 32;
  localparam int unsigned PITCH_FRAC = 16;

  localparam int unsigned NUM_REGS = 7;
  localparam int unsigned APB_AW   = 6;
  localparam int unsigned APB_DW   = 64;
  localparam int unsigned REG_IW   = 3;

  localparam logic [APB_DW-1:0] PITCH_RESET = APB_DW'(65536);

  typedef enum logic [REG_IW-1:0] {
    REG_ROW0_A = 3'd0,
    REG_ROW0_B = 3'd1,
    REG_ROW1_A = 3'd2,
    REG_ROW1_B = 3'd3,
    REG_ROW2_A = 3'd4,
    REG_ROW2_B = 3'd5,
    REG_PITCH  = 3'd6
  } reg_idx_e;

endpackage

// ===== rtl/ppp_if.sv =====
interface ppp_point_if import ppp_pkg::*; #(
  parameter int unsigned CW = COORD_WIDTH_DEF
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] point_x;
  logic signed [CW-1:0] point_y;
  logic signed [CW-1:0] point_z;

  modport source (output valid, output point_x, output point_y, output point_z, input ready);
  modport sink   (input valid, input point_x, input point_y, input point_z, output ready);
endinterface

interface ppp_pixel_if import ppp_pkg::*; #(
  parameter int unsigned CW = COORD_WIDTH_DEF
);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] pixel_u;
  logic signed [CW-1:0] pixel_v;
  logic                 in_front;
  logic                 overflow;

  modport source (output valid, output pixel_u, output pixel_v, output in_front,
                  output overflow, input ready);
  modport sink   (input valid, input pixel_u, input pixel_v, input in_front,
                  input overflow, output ready);
endinterface

// ===== rtl/ppp_div.sv =====
// Pipelined restoring divider: one quotient bit per stage, MSB first.
// Caller guarantees rem_i < div_i << QW.
module ppp_div import ppp_pkg::*; #(
  parameter int unsigned QW    = COORD_WIDTH_DEF,
  parameter int unsigned DIV_W = 2 * COEF_W + COORD_WIDTH_DEF + 2,
  parameter int unsigned REM_W = DIV_W + COORD_WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [REM_W-1:0] rem_i,
  input  logic [DIV_W-1:0] div_i,
  output logic [QW-1:0]    quo_o
);

  logic [REM_W-1:0] rem_q [QW];
  logic [DIV_W-1:0] dv_q  [QW];
  logic [QW-1:0]    q_q   [QW];

  for (genvar j = 0; j < QW; j++) begin : g_step
    logic [REM_W-1:0] r_in;
    logic [REM_W-1:0] dsh;
    logic [DIV_W-1:0] d_in;
    logic [QW-1:0]    q_in;
    logic             ge;

    if (j == 0) begin : g_first
      assign r_in = rem_i;
      assign d_in = div_i;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rem_q[j-1];
      assign d_in = dv_q[j-1];
      assign q_in = q_q[j-1];
    end

    assign dsh = REM_W'(d_in) << (QW - 1 - j);
    assign ge  = (r_in >= dsh);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= ge ? (r_in - dsh) : r_in;
        dv_q[j]  <= d_in;
        q_q[j]   <= {q_in[QW-2:0], ge};
      end
    end
  end

  assign quo_o = q_q[QW-1];

endmodule

// ===== rtl/pinhole_point_projection.sv =====
// Pinhole point projection through a 3x4 camera matrix.
// Input channel point_i carries one world point (x, y, z) per word; output
// channel pixel_o carries pixel_u, pixel_v, in_front and overflow per word.
// Each row of the matrix is dotted with (x, y, z, 1); rows 0 and 1 give the
// numerators, row 2 the depth D. u and v are numerator / (D * pitch), exact,
// truncated toward zero, saturated to COORD_WIDTH signed bits.
// Matrix and pitch are written over the APB port (64-bit registers at 8*i).
// Most of the pipeline is the long-division section, which retires one
// quotient bit per stage.
// Throughput: one word per cycle while the receiver takes every word.
// The whole pipeline advances on one enable: when the last stage holds a
// word that the receiver does not take, every stage holds and the input
// ready drops; nothing is lost or repeated.
// Reset clears all valid bits and the matrix; pitch resets to 1.0.
// Registers are sampled live, so change them only with the pipeline empty.
module pinhole_point_projection import ppp_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  ppp_point_if.sink          point_i,
  ppp_pixel_if.source        pixel_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready
);

  localparam int unsigned CW     = COORD_WIDTH;
  localparam int unsigned PROD_W = COEF_W + CW;
  localparam int unsigned OFS_W  = COEF_W + FRAC_BITS;
  localparam int unsigned SUM_W  = ((PROD_W > OFS_W) ? PROD_W : OFS_W) + 2;
  localparam int unsigned MAG_W  = SUM_W;
  localparam int unsigned LO_W   = 32;
  localparam int unsigned HI_W   = MAG_W - LO_W;
  localparam int unsigned DIV_W  = MAG_W + PITCH_W;
  localparam int unsigned SH     = PITCH_FRAC + FRAC_BITS;
  localparam int unsigned NUM_W  = MAG_W + SH;
  localparam int unsigned REM_W  = (NUM_W > DIV_W + CW) ? NUM_W : DIV_W + CW;

  // stage map
  localparam int unsigned S_MAG = 2;
  localparam int unsigned S_CHK = 4;
  localparam int unsigned S_DV0 = 5;
  localparam int unsigned S_DVL = S_DV0 + CW - 1;
  localparam int unsigned NS    = S_DVL + 2;

  localparam logic [CW-1:0] MIN_V = {1'b1, {(CW-1){1'b0}}};
  localparam logic [CW-1:0] MAX_V = ~MIN_V;

  typedef struct packed {
    logic nneg_u;
    logic nzero_u;
    logic nneg_v;
    logic nzero_v;
    logic dneg;
    logic dnz;    // D nonzero
    logic dzero;  // D * pitch is zero
    logic big_u;  // quotient >= 2^CW
    logic big_v;
  } side_t;

  // ---------------- configuration ----------------
  logic [APB_DW-1:0]  cfg_q [NUM_REGS];
  logic [REG_IW-1:0]  cfg_idx;
  logic               cfg_wr;

  assign cfg_idx = paddr[APB_AW-1:APB_AW-REG_IW];
  assign cfg_wr  = psel & penable & pwrite & (32'(cfg_idx) < NUM_REGS);
  assign pready  = 1'b1;
  assign prdata  = (32'(cfg_idx) < NUM_REGS) ? cfg_q[cfg_idx] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        cfg_q[i] <= (i == int'(REG_PITCH)) ? PITCH_RESET : '0;
      end
    end else if (cfg_wr) begin
      if (cfg_idx == REG_PITCH) begin
        cfg_q[cfg_idx] <= {{(APB_DW-PITCH_W){1'b0}}, pwdata[PITCH_W-1:0]};
      end else begin
        cfg_q[cfg_idx] <= pwdata;
      end
    end
  end

  logic signed [COEF_W-1:0] coef [3][4];
  logic [PITCH_W-1:0]       pitch;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      coef[r][0] = cfg_q[2*r][63:32];
      coef[r][1] = cfg_q[2*r][31:0];
      coef[r][2] = cfg_q[2*r+1][63:32];
      coef[r][3] = cfg_q[2*r+1][31:0];
    end
  end
  assign pitch = cfg_q[REG_PITCH][PITCH_W-1:0];

  // ---------------- pipeline control ----------------
  logic          en;
  logic [NS-1:0] vld_q;

  assign en            = !vld_q[NS-1] || pixel_o.ready;
  assign point_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NS-2:0], point_i.valid};
    end
  end

  // ---------------- stage 0: products ----------------
  logic signed [CW-1:0]     pt [3];
  logic signed [PROD_W-1:0] prod_q [3][3];

  assign pt[0] = point_i.point_x;
  assign pt[1] = point_i.point_y;
  assign pt[2] = point_i.point_z;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[r][c] <= PROD_W'(coef[r][c]) * PROD_W'(pt[c]);
        end
      end
    end
  end

  // ---------------- stage 1: row sums ----------------
  logic signed [SUM_W-1:0] sum_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        sum_q[r] <= SUM_W'(prod_q[r][0]) + SUM_W'(prod_q[r][1]) + SUM_W'(prod_q[r][2])
                  + (SUM_W'(coef[r][3]) <<< FRAC_BITS);
      end
    end
  end

  // ---------------- stage 2: magnitudes, pitch partial products ----------------
  logic [MAG_W-1:0]        mag_d [3];
  logic [MAG_W-1:0]        magu_q, magv_q;
  logic [LO_W+PITCH_W-1:0] plo_q;
  logic [HI_W+PITCH_W-1:0] phi_q;
  side_t                   side_q [S_MAG:NS-2];
  side_t                   side2_d;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      mag_d[r] = sum_q[r][SUM_W-1] ? MAG_W'(-sum_q[r]) : MAG_W'(sum_q[r]);
    end
    side2_d         = '0;
    side2_d.nneg_u  = sum_q[0][SUM_W-1];
    side2_d.nzero_u = (sum_q[0] == '0);
    side2_d.nneg_v  = sum_q[1][SUM_W-1];
    side2_d.nzero_v = (sum_q[1] == '0);
    side2_d.dneg    = sum_q[2][SUM_W-1];
    side2_d.dnz     = (sum_q[2] != '0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      magu_q        <= mag_d[0];
      magv_q        <= mag_d[1];
      plo_q         <= mag_d[2][LO_W-1:0] * pitch;
      phi_q         <= mag_d[2][MAG_W-1:LO_W] * pitch;
      side_q[S_MAG] <= side2_d;
    end
  end

  // ---------------- stage 3: divisor and shifted numerators ----------------
  logic [DIV_W-1:0] div3_q;
  logic [NUM_W-1:0] numu_q, numv_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      div3_q          <= DIV_W'(plo_q) + (DIV_W'(phi_q) << LO_W);
      numu_q          <= NUM_W'(magu_q) << SH;
      numv_q          <= NUM_W'(magv_q) << SH;
      side_q[S_MAG+1] <= side_q[S_MAG];
    end
  end

  // ---------------- stage 4: range check ----------------
  logic [REM_W-1:0] remu_q, remv_q, lim4;
  logic [DIV_W-1:0] div4_q;
  side_t            side4_d;

  assign lim4 = REM_W'(div3_q) << CW;

  always_comb begin
    side4_d       = side_q[S_MAG+1];
    side4_d.dzero = (div3_q == '0);
    side4_d.big_u = (REM_W'(numu_q) >= lim4);
    side4_d.big_v = (REM_W'(numv_q) >= lim4);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      remu_q        <= side4_d.big_u ? '0 : REM_W'(numu_q);
      remv_q        <= side4_d.big_v ? '0 : REM_W'(numv_q);
      div4_q        <= div3_q;
      side_q[S_CHK] <= side4_d;
    end
  end

  // ---------------- stages 5..: bit-per-stage division ----------------
  logic [CW-1:0] quo_u, quo_v;

  ppp_div #(.QW(CW), .DIV_W(DIV_W), .REM_W(REM_W)) u_div_u (
    .clk_i (clk_i),
    .en_i  (en),
    .rem_i (remu_q),
    .div_i (div4_q),
    .quo_o (quo_u)
  );

  ppp_div #(.QW(CW), .DIV_W(DIV_W), .REM_W(REM_W)) u_div_v (
    .clk_i (clk_i),
    .en_i  (en),
    .rem_i (remv_q),
    .div_i (div4_q),
    .quo_o (quo_v)
  );

  for (genvar k = S_DV0; k <= S_DVL; k++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (en) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // ---------------- output stage: sign and saturation ----------------
  side_t         sf;
  logic [CW-1:0] u_d, v_d;
  logic          ovu_d, ovv_d;

  always_comb begin
    sf    = side_q[S_DVL];
    ovu_d = 1'b0;
    ovv_d = 1'b0;
    if (sf.dzero) begin
      ovu_d = 1'b1;
      ovv_d = 1'b1;
      u_d   = sf.nzero_u ? '0 : (sf.nneg_u ? MIN_V : MAX_V);
      v_d   = sf.nzero_v ? '0 : (sf.nneg_v ? MIN_V : MAX_V);
    end else begin
      if (sf.nneg_u != sf.dneg) begin
        ovu_d = sf.big_u || (quo_u > MIN_V);
        u_d   = ovu_d ? MIN_V : (CW'(0) - quo_u);
      end else begin
        ovu_d = sf.big_u || (quo_u > MAX_V);
        u_d   = ovu_d ? MAX_V : quo_u;
      end
      if (sf.nneg_v != sf.dneg) begin
        ovv_d = sf.big_v || (quo_v > MIN_V);
        v_d   = ovv_d ? MIN_V : (CW'(0) - quo_v);
      end else begin
        ovv_d = sf.big_v || (quo_v > MAX_V);
        v_d   = ovv_d ? MAX_V : quo_v;
      end
    end
  end

  logic [CW-1:0] u_q, v_q;
  logic          front_q, ovf_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      u_q     <= u_d;
      v_q     <= v_d;
      front_q <= !sf.dneg && sf.dnz;
      ovf_q   <= ovu_d || ovv_d;
    end
  end

  assign pixel_o.valid    = vld_q[NS-1];
  assign pixel_o.pixel_u  = u_q;
  assign pixel_o.pixel_v  = v_q;
  assign pixel_o.in_front = front_q;
  assign pixel_o.overflow = ovf_q;

endmodule
